[rtl/core/hbd_pkg.sv]
// ----------------------------------------------------------------------------
// hbd_pkg: shared definitions for the http body dechunker
// Counter width, register indexes, framing codes, byte constants and the
// result record passed from the decode core to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

package hbd_pkg;

    // width of the length and chunk size counters (16 to 64)
    localparam int COUNT_BITS = 32;
    // width of the body_length register
    localparam int LEN_BITS   = 32;
    localparam int FRAME_BITS = 2;

    // configuration register indexes
    localparam logic [0:0] REG_FRAMING = 1'b0;
    localparam logic [0:0] REG_LENGTH  = 1'b1;

    // body framing codes
    localparam logic [FRAME_BITS-1:0] FRAME_NONE    = 2'd0;
    localparam logic [FRAME_BITS-1:0] FRAME_LENGTH  = 2'd1;
    localparam logic [FRAME_BITS-1:0] FRAME_CHUNKED = 2'd2;

    // input beat kinds (s_tuser)
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_BYTE  = 1'b1;

    // line terminator bytes
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // bytes skipped after chunk data and after the last chunk line
    localparam logic [1:0] SKIP_COUNT = 2'd2;

    // bit positions in m_tuser
    localparam int TU_VALID  = 0;
    localparam int TU_BAD    = 1;
    localparam int TU_UNCONS = 2;
    localparam int TU_BITS   = 3;

    // one decoded result
    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       done_res;
        logic       bad_size;
        logic       unconsumed;
    } res_t;

endpackage

`default_nettype wire

[rtl/core/hbd_core.sv]
// ----------------------------------------------------------------------------
// hbd_core: per-byte body decode state and result logic
// Holds the parse state; computes the result of one input beat from that
// state and updates the state when the beat is stepped.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_core (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               step,
    input  wire                               mode,
    input  wire [7:0]                         data_byte,
    input  wire [hbd_pkg::FRAME_BITS-1:0]     body_framing,
    input  wire [hbd_pkg::LEN_BITS-1:0]       body_length,
    output hbd_pkg::res_t                     res
);
    import hbd_pkg::*;

    // phase codes
    localparam logic [2:0] PH_DONE       = 3'd0;
    localparam logic [2:0] PH_LENGTH     = 3'd1;
    localparam logic [2:0] PH_SIZE       = 3'd2;
    localparam logic [2:0] PH_DATA       = 3'd3;
    localparam logic [2:0] PH_SKIP_CRLF  = 3'd4;
    localparam logic [2:0] PH_SKIP_TRAIL = 3'd5;
    localparam logic [2:0] PH_ERROR      = 3'd6;

    // hex digit decode: {is_hex, value}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    logic [2:0]            phase_reg,          phase_next;
    logic [COUNT_BITS-1:0] remaining_reg,      remaining_next;
    logic [COUNT_BITS-1:0] size_accum_reg,     size_accum_next;
    logic                  digit_seen_reg,     digit_seen_next;
    logic                  digits_stopped_reg, digits_stopped_next;
    logic                  saw_cr_reg,         saw_cr_next;
    logic [1:0]            skip_left_reg,      skip_left_next;
    logic                  error_flag_reg,     error_flag_next;

    logic [4:0]            hex;
    logic [LEN_BITS-1:0]   len_high;
    logic [COUNT_BITS-1:0] len_load;
    logic [COUNT_BITS-1:0] rem_dec;
    logic [1:0]            skip_dec;

    assign hex      = hex_decode(data_byte);
    // content length, saturated when the counter is narrower
    assign len_high = body_length >> COUNT_BITS;
    assign len_load = (len_high != '0) ? {COUNT_BITS{1'b1}} : COUNT_BITS'(body_length);
    assign rem_dec  = remaining_reg - COUNT_BITS'(1);
    assign skip_dec = skip_left_reg - 2'd1;

    // next state and result for the current beat
    always_comb begin
        phase_next          = phase_reg;
        remaining_next      = remaining_reg;
        size_accum_next     = size_accum_reg;
        digit_seen_next     = digit_seen_reg;
        digits_stopped_next = digits_stopped_reg;
        saw_cr_next         = saw_cr_reg;
        skip_left_next      = skip_left_reg;
        error_flag_next     = error_flag_reg;
        res                 = '0;

        if (mode == MODE_START) begin
            error_flag_next     = 1'b0;
            skip_left_next      = 2'd0;
            remaining_next      = '0;
            size_accum_next     = '0;
            digit_seen_next     = 1'b0;
            digits_stopped_next = 1'b0;
            saw_cr_next         = 1'b0;
            if (body_framing == FRAME_LENGTH && body_length != '0) begin
                remaining_next = len_load;
                phase_next     = PH_LENGTH;
            end else if (body_framing == FRAME_CHUNKED) begin
                phase_next = PH_SIZE;
            end else begin
                phase_next   = PH_DONE;
                res.done_res = 1'b1;
            end
        end else begin
            unique case (phase_reg)
                PH_LENGTH: begin
                    res.out_byte   = data_byte;
                    res.out_valid  = 1'b1;
                    remaining_next = rem_dec;
                    if (rem_dec == '0) begin
                        phase_next   = PH_DONE;
                        res.done_res = 1'b1;
                    end
                end
                PH_SIZE: begin
                    if (saw_cr_reg && data_byte == CH_LF) begin
                        // end of size line
                        if (!digit_seen_reg) begin
                            phase_next      = PH_ERROR;
                            error_flag_next = 1'b1;
                            res.bad_size    = 1'b1;
                        end else if (size_accum_reg == '0) begin
                            phase_next     = PH_SKIP_TRAIL;
                            skip_left_next = SKIP_COUNT;
                        end else begin
                            remaining_next = size_accum_reg;
                            phase_next     = PH_DATA;
                        end
                    end else begin
                        saw_cr_next = (data_byte == CH_CR);
                        if (!digits_stopped_reg) begin
                            if (hex[4]) begin
                                // a digit that would carry past the counter
                                if (size_accum_reg[COUNT_BITS-1 -: 4] != 4'd0) begin
                                    phase_next      = PH_ERROR;
                                    error_flag_next = 1'b1;
                                    res.bad_size    = 1'b1;
                                end else begin
                                    size_accum_next = {size_accum_reg[COUNT_BITS-5:0],
                                                       hex[3:0]};
                                    digit_seen_next = 1'b1;
                                end
                            end else if (!digit_seen_reg) begin
                                phase_next      = PH_ERROR;
                                error_flag_next = 1'b1;
                                res.bad_size    = 1'b1;
                            end else begin
                                // start of a size line extension
                                digits_stopped_next = 1'b1;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    res.out_byte   = data_byte;
                    res.out_valid  = 1'b1;
                    remaining_next = rem_dec;
                    if (rem_dec == '0) begin
                        phase_next     = PH_SKIP_CRLF;
                        skip_left_next = SKIP_COUNT;
                    end
                end
                PH_SKIP_CRLF: begin
                    skip_left_next = skip_dec;
                    if (skip_dec == 2'd0) begin
                        phase_next          = PH_SIZE;
                        size_accum_next     = '0;
                        digit_seen_next     = 1'b0;
                        digits_stopped_next = 1'b0;
                        saw_cr_next         = 1'b0;
                    end
                end
                PH_SKIP_TRAIL: begin
                    skip_left_next = skip_dec;
                    if (skip_dec == 2'd0) begin
                        phase_next   = PH_DONE;
                        res.done_res = 1'b1;
                    end
                end
                default: begin
                    res.unconsumed = 1'b1;
                    res.bad_size   = error_flag_reg;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_DONE;
            remaining_reg      <= '0;
            size_accum_reg     <= '0;
            digit_seen_reg     <= 1'b0;
            digits_stopped_reg <= 1'b0;
            saw_cr_reg         <= 1'b0;
            skip_left_reg      <= 2'd0;
            error_flag_reg     <= 1'b0;
        end else if (step) begin
            phase_reg          <= phase_next;
            remaining_reg      <= remaining_next;
            size_accum_reg     <= size_accum_next;
            digit_seen_reg     <= digit_seen_next;
            digits_stopped_reg <= digits_stopped_next;
            saw_cr_reg         <= saw_cr_next;
            skip_left_reg      <= skip_left_next;
            error_flag_reg     <= error_flag_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/http_body_dechunker.sv]
// ----------------------------------------------------------------------------
// http_body_dechunker: streaming http/1.1 message body decoder
// Takes one received byte per beat and returns one result beat per input
// beat: payload byte with flags for completion, bad chunk size and bytes
// that fall outside the body.
//
//   channel | direction | beat carries
//   --------+-----------+----------------------------------------------
//   s_      | in        | tuser: mode, tdata: data_byte
//   m_      | out       | tdata: out_byte, tlast: done_res,
//           |           | tuser: out_valid, bad_size, unconsumed
//   cfg_    | in        | index 0 body_framing, index 1 body_length
//
// An input beat goes through the input register, then decode into the
// result register. One beat per cycle is sustained while m_tready is high;
// the decode state update for one byte is a single shift-add and counter step.
// Reset (aresetn low, synchronous) clears the parse state, both beat valid
// flags and the configuration registers. A stalled m_ side holds the
// result register and then the input register, after which s_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module http_body_dechunker (
    input  wire                              aclk,
    input  wire                              aresetn,
    // input stream
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire  [7:0]                       s_tdata,   // [7:0] data_byte
    input  wire  [0:0]                       s_tuser,   // [0] mode
    // result stream
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [7:0]                       m_tdata,   // [7:0] out_byte
    output logic                             m_tlast,   // done_res
    output logic [hbd_pkg::TU_BITS-1:0]      m_tuser,   // [0] out_valid [1] bad_size
                                                        // [2] unconsumed
    // configuration writes
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire  [0:0]                       cfg_index,
    input  wire  [hbd_pkg::LEN_BITS-1:0]     cfg_data
);
    import hbd_pkg::*;

    logic                  in_valid_reg;
    logic                  in_mode_reg;
    logic [7:0]            in_byte_reg;
    logic                  out_valid_reg;
    res_t                  out_res_reg;
    logic [FRAME_BITS-1:0] body_framing_reg;
    logic [LEN_BITS-1:0]   body_length_reg;
    logic                  step;
    res_t                  res;

    // decode fires when the result register is free or being drained
    assign step      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            body_framing_reg <= FRAME_NONE;
            body_length_reg  <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_FRAMING: body_framing_reg <= cfg_data[FRAME_BITS-1:0];
                REG_LENGTH:  body_length_reg  <= cfg_data;
                default:     body_length_reg  <= body_length_reg;
            endcase
        end
    end

    // input beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg <= s_tuser[0];
            in_byte_reg <= s_tdata;
        end
    end

    hbd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .mode         (in_mode_reg),
        .data_byte    (in_byte_reg),
        .body_framing (body_framing_reg),
        .body_length  (body_length_reg),
        .res          (res)
    );

    // result beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid           = out_valid_reg;
    assign m_tdata            = out_res_reg.out_byte;
    assign m_tlast            = out_res_reg.done_res;
    assign m_tuser[TU_VALID]  = out_res_reg.out_valid;
    assign m_tuser[TU_BAD]    = out_res_reg.bad_size;
    assign m_tuser[TU_UNCONS] = out_res_reg.unconsumed;

endmodule

`default_nettype wire

[rtl/core/hbd_checker.sv]
// ----------------------------------------------------------------------------
// hbd_checker: port-level assertions for the http body dechunker
// Watches the result stream for held beats and consistent result flags.
// ----------------------------------------------------------------------------
`default_nettype none

module hbd_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [7:0]                    m_tdata,
    input wire                          m_tlast,
    input wire [hbd_pkg::TU_BITS-1:0]   m_tuser
);
    import hbd_pkg::*;

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // payload bytes are never flagged as outside the body or as errors
    a_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[TU_VALID] |-> !m_tuser[TU_UNCONS] && !m_tuser[TU_BAD])
        else $error("payload beat carries error flags");

    // non-payload beats carry a zero byte
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[TU_VALID] |-> m_tdata == 8'd0)
        else $error("non-payload beat with nonzero byte");

    // completion never marks a byte outside the body
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser[TU_UNCONS] && !m_tuser[TU_BAD])
        else $error("completion beat flagged unconsumed or bad");

endmodule

bind http_body_dechunker hbd_checker u_hbd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: http body dechunker
// Sends start and byte beats under no-body, content-length and chunked
// framing, directed first and then as random well-formed bodies with some
// noise. A scoreboard class predicts each result beat from the accepted
// input beats and checks the result stream field by field while both
// stream sides idle at random.
// ----------------------------------------------------------------------------

module testbench;
    import hbd_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 650;
    localparam int LATENCY_WAIT = 4;
    localparam int SENDER_IDLE[4]    = '{0, 78, 0, 38};
    localparam int RECEIVER_STALL[4] = '{0, 0, 78, 38};

    // unused framing code, decoded as no body
    localparam logic [FRAME_BITS-1:0] FRAME_SPARE = 2'd3;

    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_SEMI    = 8'h3B;

    typedef enum logic [2:0] {
        PH_DONE, PH_LENGTH, PH_SIZE, PH_DATA, PH_SKIP_CRLF, PH_SKIP_TRAIL, PH_ERROR
    } body_phase_t;

    // body decoder prediction and result checking
    class body_scoreboard;
        logic [FRAME_BITS-1:0] framing;
        logic [LEN_BITS-1:0]   length;
        body_phase_t           phase;
        logic [COUNT_BITS-1:0] remaining;
        logic [COUNT_BITS-1:0] size_acc;
        logic                  digit_seen;
        logic                  digits_stopped;
        logic                  saw_cr;
        logic                  error_flag;
        logic [1:0]            skip_left;
        res_t                  expected_q[$];
        int                    errors;

        function new();
            framing    = FRAME_NONE;
            length     = '0;
            phase      = PH_DONE;
            remaining  = '0;
            skip_left  = '0;
            error_flag = 1'b0;
            errors     = 0;
            clear_line();
        endfunction

        function void clear_line();
            size_acc       = '0;
            digit_seen     = 1'b0;
            digits_stopped = 1'b0;
            saw_cr         = 1'b0;
        endfunction

        function int hex_value(logic [7:0] c);
            if (c >= ASCII_ZERO && c <= ASCII_ZERO + 8'd9) return int'(c - ASCII_ZERO);
            if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_A + 8'd5)
                return int'(c - ASCII_LOWER_A) + 10;
            if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_A + 8'd5)
                return int'(c - ASCII_UPPER_A) + 10;
            return -1;
        endfunction

        function void write_reg(logic [0:0] index, logic [LEN_BITS-1:0] value);
            if (index == REG_FRAMING) framing = value[FRAME_BITS-1:0];
            else length = value;
        endfunction

        // advance the decoder by one accepted input beat
        function void note_input(logic mode, logic [7:0] data);
            res_t        r;
            int          digit;
            logic        bad;
            logic [63:0] count_max;
            r = '0;
            bad = 1'b0;
            count_max = {64{1'b1}} >> (64 - COUNT_BITS);
            if (mode == MODE_START) begin
                error_flag = 1'b0;
                skip_left  = '0;
                remaining  = '0;
                clear_line();
                if (framing == FRAME_LENGTH && length != 0) begin
                    // a length beyond the counter saturates
                    remaining = (64'(length) > count_max) ? '1 : COUNT_BITS'(length);
                    phase = PH_LENGTH;
                end else if (framing == FRAME_CHUNKED) begin
                    phase = PH_SIZE;
                end else begin
                    phase = PH_DONE;
                    r.done_res = 1'b1;
                end
            end else begin
                case (phase) inside
                    PH_LENGTH, PH_DATA: begin
                        r.out_byte  = data;
                        r.out_valid = 1'b1;
                        remaining = remaining - 1'b1;
                        if (remaining == 0) begin
                            if (phase == PH_LENGTH) begin
                                phase = PH_DONE;
                                r.done_res = 1'b1;
                            end else begin
                                phase = PH_SKIP_CRLF;
                                skip_left = SKIP_COUNT;
                            end
                        end
                    end
                    PH_SIZE: begin
                        digit = hex_value(data);
                        if (saw_cr && data == CH_LF) begin
                            // end of the size line
                            if (!digit_seen) begin
                                bad = 1'b1;
                            end else if (size_acc == 0) begin
                                phase = PH_SKIP_TRAIL;
                                skip_left = SKIP_COUNT;
                            end else begin
                                remaining = size_acc;
                                phase = PH_DATA;
                            end
                        end else begin
                            saw_cr = (data == CH_CR);
                            if (!digits_stopped) begin
                                if (digit >= 0) begin
                                    if ((size_acc >> (COUNT_BITS - 4)) != 0) begin
                                        bad = 1'b1;
                                    end else begin
                                        size_acc = (size_acc << 4) + COUNT_BITS'(digit);
                                        digit_seen = 1'b1;
                                    end
                                end else if (!digit_seen) begin
                                    bad = 1'b1;
                                end else begin
                                    digits_stopped = 1'b1;
                                end
                            end
                        end
                        if (bad) begin
                            phase = PH_ERROR;
                            error_flag = 1'b1;
                            r.bad_size = 1'b1;
                        end
                    end
                    PH_SKIP_CRLF: begin
                        skip_left = skip_left - 1'b1;
                        if (skip_left == 0) begin
                            phase = PH_SIZE;
                            clear_line();
                        end
                    end
                    PH_SKIP_TRAIL: begin
                        skip_left = skip_left - 1'b1;
                        if (skip_left == 0) begin
                            phase = PH_DONE;
                            r.done_res = 1'b1;
                        end
                    end
                    default: begin
                        r.unconsumed = 1'b1;
                        r.bad_size   = error_flag;
                    end
                endcase
            end
            expected_q.push_back(r);
        endfunction

        // compare one result beat with the oldest prediction
        function void check_result(logic [7:0] data, logic tlast_v, logic [TU_BITS-1:0] user);
            res_t want;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected: tdata %0h", data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (data !== want.out_byte) begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, data);
                errors++;
            end
            if (user[TU_VALID] !== want.out_valid) begin
                $error("out_valid: expected %0b, actual %0b", want.out_valid, user[TU_VALID]);
                errors++;
            end
            if (tlast_v !== want.done_res) begin
                $error("done_res: expected %0b, actual %0b", want.done_res, tlast_v);
                errors++;
            end
            if (user[TU_BAD] !== want.bad_size) begin
                $error("bad_size: expected %0b, actual %0b", want.bad_size, user[TU_BAD]);
                errors++;
            end
            if (user[TU_UNCONS] !== want.unconsumed) begin
                $error("unconsumed: expected %0b, actual %0b", want.unconsumed,
                       user[TU_UNCONS]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic [TU_BITS-1:0]    m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [0:0]            cfg_index = '0;
    logic [LEN_BITS-1:0]   cfg_data  = '0;

    body_scoreboard        sb = new();
    int                    sender_idle_pct    = 0;
    int                    receiver_stall_pct = 0;
    int                    items_sent         = 0;
    int unsigned           cycles             = 0;
    logic [FRAME_BITS-1:0] cur_framing;
    logic [LEN_BITS-1:0]   cur_length;
    logic [7:0]            msg_q[$];

    http_body_dechunker dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // result side back-pressure
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // result beat monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
    end

    // run time guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // one input beat, with random idle cycles ahead of it
    task automatic send_item(logic mode, logic [7:0] data);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_input(mode, data);
        items_sent++;
        @(negedge aclk);
    endtask

    // register write once every result is back
    task automatic write_reg(logic [0:0] index, logic [LEN_BITS-1:0] value);
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (LATENCY_WAIT) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.write_reg(index, value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // framing code with random upper bits on the write data
    task automatic set_framing(logic [FRAME_BITS-1:0] code);
        cur_framing = code;
        write_reg(REG_FRAMING, {(LEN_BITS - FRAME_BITS)'($urandom()), code});
    endtask

    task automatic set_length(logic [LEN_BITS-1:0] value);
        cur_length = value;
        write_reg(REG_LENGTH, value);
    endtask

    // start beat followed by the queued body bytes
    task automatic send_message();
        send_item(MODE_START, 8'($urandom()));
        foreach (msg_q[i]) send_item(MODE_BYTE, msg_q[i]);
    endtask

    function automatic logic [7:0] hex_char(int unsigned v);
        if (v < 10) return ASCII_ZERO + 8'(v);
        return ($urandom_range(1) ? ASCII_UPPER_A : ASCII_LOWER_A) + 8'(v - 10);
    endfunction

    // hex size line with optional leading zeros and extension
    function automatic void push_size_line(logic [COUNT_BITS-1:0] size);
        int unsigned digits[$];
        if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) msg_q.push_back(ASCII_ZERO);
        do begin
            digits.push_front(size[3:0]);
            size = size >> 4;
        end while (size != 0);
        foreach (digits[i]) msg_q.push_back(hex_char(digits[i]));
        if ($urandom_range(5) == 0) begin
            msg_q.push_back(ASCII_SEMI);
            repeat ($urandom_range(3)) msg_q.push_back(ASCII_LOWER_A + 8'($urandom_range(25)));
        end
        msg_q.push_back(CH_CR);
        msg_q.push_back(CH_LF);
    endfunction

    // two bytes after chunk data, mostly CR LF
    function automatic void push_skip_pair();
        if ($urandom_range(4) != 0) begin
            msg_q.push_back(CH_CR);
            msg_q.push_back(CH_LF);
        end else begin
            repeat (2) msg_q.push_back(8'($urandom()));
        end
    endfunction

    // chunked body: up to three chunks and the last chunk, sometimes a broken size line or an abandoned huge chunk
    function automatic void build_chunked();
        int          pick;
        int unsigned size;
        pick = $urandom_range(99);
        if (pick < 5) begin
            // non-hex start of the size line
            case ($urandom_range(2))
                0: msg_q.push_back(CH_CR);
                1: msg_q.push_back(8'($urandom_range(8'h2F)));
                default: msg_q.push_back(8'($urandom_range(8'hFF, 8'h67)));
            endcase
            msg_q.push_back(CH_CR);
            msg_q.push_back(CH_LF);
            return;
        end
        if (pick < 10) begin
            // one or two digits more than the counter holds
            msg_q.push_back(hex_char($urandom_range(15, 1)));
            repeat (COUNT_BITS / 4 + $urandom_range(1))
                msg_q.push_back(hex_char($urandom_range(15)));
            msg_q.push_back(CH_CR);
            msg_q.push_back(CH_LF);
            return;
        end
        if (pick < 13) begin
            // huge chunk, abandoned after one to five bytes
            push_size_line(COUNT_BITS'($urandom()) | (COUNT_BITS'(1) << (COUNT_BITS - 4)));
            repeat ($urandom_range(1, 5)) msg_q.push_back(8'($urandom()));
            return;
        end
        repeat ($urandom_range(3)) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
            push_size_line(size);
            repeat (size) msg_q.push_back(8'($urandom()));
            push_skip_pair();
        end
        push_size_line('0);
        push_skip_pair();
    endfunction

    // keep only a random leading part of the queued body
    function automatic void size_t_trim(int unsigned max_keep);
        int unsigned keep;
        keep = $urandom_range(max_keep, 1);
        while (msg_q.size() > keep) msg_q.delete(msg_q.size() - 1);
    endfunction

    // one random body under the current settings, with some noise
    task automatic run_message();
        msg_q.delete();
        if (cur_framing == FRAME_LENGTH) begin
            if (cur_length <= 64) repeat (cur_length) msg_q.push_back(8'($urandom()));
            else repeat ($urandom_range(6, 1)) msg_q.push_back(8'($urandom()));
        end else if (cur_framing == FRAME_CHUNKED) begin
            build_chunked();
        end
        // abandon early
        if (msg_q.size() > 1 && $urandom_range(99) < 10) begin
            size_t_trim(msg_q.size() - 1);
        end
        // corrupt one byte
        if (msg_q.size() > 0 && $urandom_range(99) < 8)
            msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom());
        // stray bytes after the body
        if ($urandom_range(99) < 20) repeat ($urandom_range(2, 1)) msg_q.push_back(8'($urandom()));
        send_message();
    endtask

    // random framing and length, extremes included
    task automatic pick_settings();
        int p;
        p = $urandom_range(99);
        if (p < 10) set_framing(FRAME_NONE);
        else if (p < 15) set_framing(FRAME_SPARE);
        else if (p < 50) set_framing(FRAME_LENGTH);
        else set_framing(FRAME_CHUNKED);
        p = $urandom_range(99);
        if (p < 10) set_length('0);
        else if (p < 15) set_length('1);
        else if (p < 22) set_length($urandom());
        else if (p < 35) set_length($urandom_range(64, 13));
        else set_length($urandom_range(12, 1));
    endtask

    initial begin
        int target;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // byte before any start, then no-body framing from reset
        send_item(MODE_BYTE, 8'h5A);
        send_item(MODE_START, 8'hFF);
        set_framing(FRAME_SPARE);
        send_item(MODE_START, 8'h00);

        // zero content length completes on the start beat
        set_framing(FRAME_LENGTH);
        set_length('0);
        send_item(MODE_START, 8'h00);

        // largest content length, left unfinished
        set_length('1);
        msg_q = '{8'h00, 8'hFF};
        send_message();

        // chunked start abandons that body; empty size line is bad
        set_framing(FRAME_CHUNKED);
        msg_q = '{CH_CR, 8'h41};
        send_message();

        // one chunk with extension, last chunk, unchecked trailing pair
        msg_q = '{"1", ";", CH_CR, CH_LF, 8'hA5, "x", "y", "0", CH_CR, CH_LF, "z", "z"};
        send_message();

        // size line overflowing the counter
        msg_q.delete();
        repeat (COUNT_BITS / 4 + 1) msg_q.push_back($urandom_range(1) ? "F" : "f");
        send_message();

        // random bodies over the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            sender_idle_pct    = SENDER_IDLE[ph];
            receiver_stall_pct = RECEIVER_STALL[ph];
            target = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < target) begin
                pick_settings();
                repeat ($urandom_range(4, 1)) run_message();
            end
        end

        // drain
        s_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(negedge aclk);
        repeat (LATENCY_WAIT * 4) @(negedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
